@@ design/csvtok_pkg.sv @@
// Package with shared types, codes and reset constants of the CSV field tokenizer.
`timescale 1ns / 1ps

package csvtok_pkg;

  localparam logic [7:0] DelimReset  = 8'h2c;
  localparam logic [7:0] QuoteReset  = 8'h22;
  localparam logic [7:0] RowEndReset = 8'h0a;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  // Register indexes on the configuration port (byte address / 4).
  typedef enum logic [1:0] {
    REG_DELIM   = 2'd0,
    REG_QUOTE   = 2'd1,
    REG_ROW_END = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_CELL     = 2'd1,
    KIND_CELL_ROW = 2'd2,
    KIND_ROW      = 2'd3
  } kind_t;

  // Quote tracking; the unused code is handled as outside quotes.
  typedef enum logic [1:0] {
    QM_OUTSIDE    = 2'd0,
    QM_INSIDE     = 2'd1,
    QM_CLOSE_PEND = 2'd2
  } quote_mode_t;

  typedef struct packed {
    logic [7:0] delim;
    logic [7:0] quote;
    logic [7:0] row_end;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    kind_t      kind;
  } res_t;

endpackage

@@ design/csvtok_cfg_regs.sv @@
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module csvtok_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [csvtok_pkg::AddrWidth-1:0]   paddr,
  input  logic [csvtok_pkg::DataWidth-1:0]   pwdata,
  output logic [csvtok_pkg::DataWidth-1:0]   prdata,
  output logic                               pready,
  output csvtok_pkg::cfg_t                   cfg
);

  csvtok_pkg::cfg_t cfg_r;
  logic             wr_en;
  logic [1:0]       idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delim   <= csvtok_pkg::DelimReset;
      cfg_r.quote   <= csvtok_pkg::QuoteReset;
      cfg_r.row_end <= csvtok_pkg::RowEndReset;
    end else if (wr_en) begin
      case (idx)
        csvtok_pkg::REG_DELIM:   cfg_r.delim   <= pwdata[7:0];
        csvtok_pkg::REG_QUOTE:   cfg_r.quote   <= pwdata[7:0];
        csvtok_pkg::REG_ROW_END: cfg_r.row_end <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      csvtok_pkg::REG_DELIM:   prdata[7:0] = cfg_r.delim;
      csvtok_pkg::REG_QUOTE:   prdata[7:0] = cfg_r.quote;
      csvtok_pkg::REG_ROW_END: prdata[7:0] = cfg_r.row_end;
      default:                 prdata      = '0;
    endcase
  end

endmodule

@@ design/csvtok_in_stage.sv @@
// Input register that holds one accepted word until the tokenizer step consumes it.
`timescale 1ns / 1ps

module csvtok_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  input  logic       go,
  output logic       hold_valid,
  output logic [7:0] hold_byte,
  output logic       hold_eos
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       eos_r;
  logic       take;

  // The register frees up in the same cycle its word is consumed.
  assign in_stall   = valid_r && !go;
  assign take       = in_valid && !in_stall;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;
  assign hold_eos   = eos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (go) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
      eos_r  <= in_end_of_stream;
    end
  end

endmodule

@@ design/csvtok_step.sv @@
// Tokenizer state and the per-byte rule that turns one word into at most one result.
`timescale 1ns / 1ps

module csvtok_step (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csvtok_pkg::cfg_t       cfg,
  input  logic                   item_valid,
  input  logic [7:0]             item_byte,
  input  logic                   item_eos,
  input  logic                   go,
  output csvtok_pkg::res_t       res
);

  csvtok_pkg::quote_mode_t qm_r, qm_nxt;
  logic cell_start_r, cell_start_nxt;
  logic row_start_r, row_start_nxt;

  logic       plain_delim;
  logic       plain_row;
  logic       is_quote;
  logic       plain;
  logic       quoted_data;

  assign is_quote    = (item_byte == cfg.quote);
  assign plain_delim = (item_byte == cfg.delim);
  assign plain_row   = (item_byte == cfg.row_end);

  // The byte is unquoted text right after a closing quote, or outside quotes
  // unless it opens a quoted cell.
  assign plain = !item_eos &&
                 ((qm_r == csvtok_pkg::QM_CLOSE_PEND) ? !is_quote :
                  ((qm_r != csvtok_pkg::QM_INSIDE) && !(cell_start_r && is_quote)));

  // Content inside quotes, including one quote of a doubled pair.
  assign quoted_data = !item_eos &&
                       (((qm_r == csvtok_pkg::QM_INSIDE) && !is_quote) ||
                        ((qm_r == csvtok_pkg::QM_CLOSE_PEND) && is_quote));

  always_comb begin
    qm_nxt         = qm_r;
    cell_start_nxt = cell_start_r;
    row_start_nxt  = row_start_r;

    if (item_eos) begin
      qm_nxt         = csvtok_pkg::QM_OUTSIDE;
      cell_start_nxt = 1'b1;
      row_start_nxt  = 1'b1;
    end else begin
      case (qm_r)
        csvtok_pkg::QM_INSIDE: begin
          if (is_quote) begin
            qm_nxt = csvtok_pkg::QM_CLOSE_PEND;
          end
        end
        csvtok_pkg::QM_CLOSE_PEND: begin
          if (is_quote) begin
            qm_nxt = csvtok_pkg::QM_INSIDE;
          end else begin
            qm_nxt = csvtok_pkg::QM_OUTSIDE;
          end
        end
        default: begin
          qm_nxt = csvtok_pkg::QM_OUTSIDE;
          if (cell_start_r && is_quote) begin
            qm_nxt         = csvtok_pkg::QM_INSIDE;
            cell_start_nxt = 1'b0;
            row_start_nxt  = 1'b0;
          end
        end
      endcase

      if (plain) begin
        if (plain_delim) begin
          cell_start_nxt = 1'b1;
          row_start_nxt  = 1'b0;
        end else if (plain_row) begin
          cell_start_nxt = 1'b1;
          row_start_nxt  = 1'b1;
        end else begin
          cell_start_nxt = 1'b0;
          row_start_nxt  = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res.valid = 1'b0;
    res.data  = 8'h00;
    res.kind  = csvtok_pkg::KIND_BYTE;

    if (item_eos) begin
      if (!cell_start_r) begin
        res.valid = 1'b1;
        res.kind  = csvtok_pkg::KIND_CELL_ROW;
      end else if (!row_start_r) begin
        res.valid = 1'b1;
        res.kind  = csvtok_pkg::KIND_ROW;
      end
    end else if (plain) begin
      res.valid = 1'b1;
      if (plain_delim) begin
        res.kind = csvtok_pkg::KIND_CELL;
      end else if (plain_row) begin
        res.kind = csvtok_pkg::KIND_CELL_ROW;
      end else begin
        res.data = item_byte;
      end
    end else if (quoted_data) begin
      res.valid = 1'b1;
      res.data  = item_byte;
    end

    if (!item_valid) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r         <= csvtok_pkg::QM_OUTSIDE;
      cell_start_r <= 1'b1;
      row_start_r  <= 1'b1;
    end else if (go) begin
      qm_r         <= qm_nxt;
      cell_start_r <= cell_start_nxt;
      row_start_r  <= row_start_nxt;
    end
  end

endmodule

@@ design/csvtok_out_stage.sv @@
// Result register that presents one word on the output channel until it is taken.
`timescale 1ns / 1ps

module csvtok_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csvtok_pkg::res_t       res,
  input  logic                   load,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic [1:0]             out_kind
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic [1:0] kind_r;

  // Free when empty or when the waiting word leaves at this edge.
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= res.data;
      kind_r <= res.kind;
    end
  end

endmodule

@@ design/csv_field_tokenizer_unit.sv @@
// Top level of the CSV field tokenizer: input register, per-byte rule, result register.
// A word accepted into the input register passes through the per-byte rule into the result
//   register, which presents its result; words that yield no result vanish.
// Throughput: one word per cycle while the result channel is not stalled.
// Reset (rst_n low, synchronous) empties both registers, restores the default characters
//   and puts the tokenizer at the start of a cell and a row outside quotes.
`timescale 1ns / 1ps

module csv_field_tokenizer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel: one raw byte, or an end-of-stream flush, per word.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_byte,
  input  logic                               in_end_of_stream,
  // Result channel: a content byte or a cell/row mark per word.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_byte,
  output logic [1:0]                         out_kind,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [csvtok_pkg::AddrWidth-1:0]   paddr,
  input  logic [csvtok_pkg::DataWidth-1:0]   pwdata,
  output logic [csvtok_pkg::DataWidth-1:0]   prdata,
  output logic                               pready
);

  csvtok_pkg::cfg_t cfg;
  csvtok_pkg::res_t res;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_eos;
  logic       out_free;
  logic       go;
  logic       load;

  // The held word advances when the result register can take its result, or at
  // once when it produces none (an opening quote, a first closing quote, an
  // end of stream with nothing open). The tokenizer state moves with it.
  assign go   = hold_valid && (out_free || !res.valid);
  assign load = go && res.valid;

  csvtok_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csvtok_in_stage u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .go               (go),
    .hold_valid       (hold_valid),
    .hold_byte        (hold_byte),
    .hold_eos         (hold_eos)
  );

  // Per-byte rule: quote handling first, then delimiter, then row end.
  csvtok_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (hold_valid),
    .item_byte  (hold_byte),
    .item_eos   (hold_eos),
    .go         (go),
    .res        (res)
  );

  csvtok_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .load      (load),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_kind  (out_kind)
  );

endmodule

@@ design/csvtok_checker.sv @@
// Port-level checker for the CSV field tokenizer, bound to the top level.
`timescale 1ns / 1ps

module csvtok_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind))
    else $error("stalled result word changed");

  // Cell and row marks carry a zero byte.
  a_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != csvtok_pkg::KIND_BYTE) |-> out_byte == 8'h00)
    else $error("mark word with nonzero byte");

  // Input is never held back while the output side is taking words.
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

endmodule

bind csv_field_tokenizer_unit csvtok_checker u_csvtok_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_kind  (out_kind)
);
